// ----- rtl/bta_pkg.sv -----
package bta_pkg;

  // Arena geometry
  localparam int ARENA_UNITS = 1024;
  localparam int UNITS_MIN   = 8;
  localparam int TAG_UNITS   = 2;

  localparam int AW = $clog2(ARENA_UNITS);  // tag index width
  localparam int NW = AW + 1;               // arena size width
  localparam int TW = AW + 2;               // signed tag width

  typedef logic [AW-1:0]        idx_t;
  typedef logic [NW-1:0]        units_t;
  typedef logic signed [TW-1:0] tag_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Shared adder operation: x + (inv ? ~y : y) + c
  typedef struct packed {
    tag_t              x;
    tag_t              y;
    logic              inv;
    logic signed [2:0] c;
  } alu_op_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    tag_t wdata;
    logic re;
    idx_t raddr;
  } ram_req_t;

  typedef struct packed {
    logic mode;
    idx_t req;
    idx_t handle;
  } req_t;

  typedef struct packed {
    status_t status;
    idx_t    address;
    idx_t    granted;
  } res_t;

  typedef struct packed {
    logic start;
    logic init;
    logic res_ready;
  } ctl_in_t;

  typedef struct packed {
    logic idle;
    logic done;
    res_t res;
  } ctl_out_t;

  function automatic tag_t ext_idx(idx_t v);
    return {{(TW-AW){1'b0}}, v};
  endfunction

  function automatic tag_t ext_units(units_t v);
    return {{(TW-NW){1'b0}}, v};
  endfunction

endpackage

// ----- rtl/bta_if.sv -----
interface bta_req_if;
  import bta_pkg::*;
  logic valid;
  logic ready;
  logic mode;
  idx_t request_units;
  idx_t handle;
  modport source (output valid, mode, request_units, handle, input ready);
  modport sink   (input valid, mode, request_units, handle, output ready);
endinterface

interface bta_rsp_if;
  import bta_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  idx_t    address;
  idx_t    granted_units;
  modport source (output valid, status, address, granted_units, input ready);
  modport sink   (input valid, status, address, granted_units, output ready);
endinterface

interface bta_cfg_if;
  import bta_pkg::*;
  logic   valid;
  logic   ready;
  units_t arena_units;
  modport source (output valid, arena_units, input ready);
  modport sink   (input valid, arena_units, output ready);
endinterface

// ----- rtl/bta_tag_ram.sv -----
module bta_tag_ram (
  input  logic              clk,
  input  bta_pkg::ram_req_t req,
  output bta_pkg::tag_t     rdata
);
  import bta_pkg::*;

  tag_t mem [ARENA_UNITS];
  tag_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bta_alu.sv -----
module bta_alu (
  input  bta_pkg::alu_op_t op,
  output bta_pkg::tag_t    res
);
  import bta_pkg::*;

  tag_t ymux;
  tag_t cext;

  assign ymux = op.inv ? ~op.y : op.y;
  assign cext = {{(TW-3){op.c[2]}}, op.c};
  assign res  = op.x + ymux + cext;

endmodule

// ----- rtl/bta_ctrl.sv -----
module bta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  bta_pkg::ctl_in_t  ctl_in,
  input  bta_pkg::req_t     req,
  input  bta_pkg::units_t   arena_units,
  input  bta_pkg::tag_t     alu_res,
  input  bta_pkg::tag_t     rdata,
  output bta_pkg::alu_op_t  alu_op,
  output bta_pkg::ram_req_t ram_req,
  output bta_pkg::ctl_out_t ctl_out
);
  import bta_pkg::*;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_INIT2, S_IDLE, S_FPRE,
    S_RD, S_MAG, S_CMP, S_ADV,
    S_G0, S_G1, S_G2, S_G3, S_G4,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_DONE
  } state_t;

  localparam logic signed [2:0] C_0  = 3'sd0;
  localparam logic signed [2:0] C_P1 = 3'sd1;
  localparam logic signed [2:0] C_P2 = 3'(TAG_UNITS);
  localparam logic signed [2:0] C_P3 = 3'sd3;
  localparam logic signed [2:0] C_M1 = -3'sd1;
  localparam logic signed [2:0] C_M2 = -3'sd2;

  state_t state_r;
  logic   mode_r;
  idx_t   req_r;
  idx_t   handle_r;
  idx_t   hm1_r;     // handle - 1: start tag of the block being freed
  idx_t   tp_r;      // start tag index of the block under the walk
  idx_t   a_r;       // payload size of that block
  logic   free_r;
  idx_t   g_r;
  idx_t   last_r;    // index of the final tag, arena_units - 1
  idx_t   r0_r;      // end tag of the block being freed
  idx_t   ltag_r;    // merged block start tag
  idx_t   rtag_r;    // merged block end tag
  tag_t   nfs_r;     // negated free size to write
  res_t   res_r;

  always_comb begin
    alu_op = '0;
    ram_req = '0;
    unique case (state_r)
      S_INIT0: begin
        alu_op = '{x: '0, y: ext_units(arena_units), inv: 1'b1, c: C_P3};
      end
      S_INIT1: begin
        alu_op = '{x: ext_units(arena_units), y: '0, inv: 1'b0, c: C_M1};
        ram_req.we = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = nfs_r;
      end
      S_INIT2: begin
        ram_req.we = 1'b1;
        ram_req.waddr = last_r;
        ram_req.wdata = nfs_r;
      end
      S_FPRE: begin
        alu_op = '{x: ext_idx(handle_r), y: '0, inv: 1'b0, c: C_M1};
      end
      S_RD: begin
        ram_req.re = 1'b1;
        ram_req.raddr = tp_r;
      end
      S_MAG: begin
        alu_op = '{x: '0, y: rdata, inv: rdata[TW-1], c: (rdata[TW-1] ? C_P1 : C_0)};
      end
      S_CMP: begin
        alu_op = '{x: ext_idx(a_r), y: ext_idx(req_r), inv: 1'b1, c: C_P1};
      end
      S_ADV: begin
        alu_op = '{x: ext_idx(tp_r), y: ext_idx(a_r), inv: 1'b0, c: C_P2};
      end
      S_G0: begin
        alu_op = '{x: ext_idx(g_r), y: ext_idx(a_r), inv: 1'b1, c: C_P3};
      end
      S_G1: begin
        alu_op = '{x: ext_idx(tp_r), y: ext_idx(g_r), inv: 1'b0, c: C_P2};
        ram_req.we = 1'b1;
        ram_req.waddr = alu_res[AW-1:0];
        ram_req.wdata = nfs_r;
      end
      S_G2: begin
        alu_op = '{x: ext_idx(tp_r), y: ext_idx(a_r), inv: 1'b0, c: C_P1};
        ram_req.we = 1'b1;
        ram_req.waddr = alu_res[AW-1:0];
        ram_req.wdata = nfs_r;
      end
      S_G3: begin
        alu_op = '{x: ext_idx(tp_r), y: '0, inv: 1'b0, c: C_P1};
        ram_req.we = 1'b1;
        ram_req.waddr = tp_r;
        ram_req.wdata = ext_idx(g_r);
      end
      S_G4: begin
        alu_op = '{x: ext_idx(tp_r), y: ext_idx(g_r), inv: 1'b0, c: C_P1};
        ram_req.we = 1'b1;
        ram_req.waddr = alu_res[AW-1:0];
        ram_req.wdata = ext_idx(g_r);
      end
      S_M0: begin
        alu_op = '{x: ext_idx(tp_r), y: ext_idx(a_r), inv: 1'b0, c: C_P1};
      end
      S_M1: begin
        alu_op = '{x: ext_idx(tp_r), y: '0, inv: 1'b0, c: C_M1};
        ram_req.re = 1'b1;
        ram_req.raddr = alu_res[AW-1:0];
      end
      S_M2: begin
        alu_op = '{x: ext_idx(tp_r), y: rdata, inv: 1'b0, c: C_M2};
      end
      S_M3: begin
        alu_op = '{x: ext_idx(r0_r), y: '0, inv: 1'b0, c: C_P1};
        ram_req.re = 1'b1;
        ram_req.raddr = alu_res[AW-1:0];
      end
      S_M4: begin
        alu_op = '{x: ext_idx(r0_r), y: rdata, inv: 1'b1, c: C_P3};
      end
      S_M5: begin
        alu_op = '{x: ext_idx(ltag_r), y: ext_idx(rtag_r), inv: 1'b1, c: C_P2};
        ram_req.we = 1'b1;
        ram_req.waddr = tp_r;
        ram_req.wdata = '0;
      end
      S_M6: begin
        ram_req.we = 1'b1;
        ram_req.waddr = r0_r;
        ram_req.wdata = '0;
      end
      S_M7: begin
        ram_req.we = 1'b1;
        ram_req.waddr = ltag_r;
        ram_req.wdata = nfs_r;
      end
      S_M8: begin
        ram_req.we = 1'b1;
        ram_req.waddr = rtag_r;
        ram_req.wdata = nfs_r;
      end
      default: begin
      end
    endcase
  end

  assign ctl_out.idle = (state_r == S_IDLE);
  assign ctl_out.done = (state_r == S_DONE) && ctl_in.res_ready;
  assign ctl_out.res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT0;
    end else begin
      unique case (state_r)
        S_INIT0: begin
          nfs_r <= alu_res;
          state_r <= S_INIT1;
        end
        S_INIT1: begin
          last_r <= alu_res[AW-1:0];
          state_r <= S_INIT2;
        end
        S_INIT2: begin
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (ctl_in.init) begin
            state_r <= S_INIT0;
          end else if (ctl_in.start) begin
            mode_r <= req.mode;
            req_r <= (req.req == '0) ? idx_t'(1) : req.req;
            handle_r <= req.handle;
            tp_r <= '0;
            res_r <= '{status: ST_OK, address: '0, granted: '0};
            if (req.mode == MODE_FREE) begin
              state_r <= (req.handle == '0) ? S_DONE : S_FPRE;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_FPRE: begin
          hm1_r <= alu_res[AW-1:0];
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_MAG;
        end
        S_MAG: begin
          a_r <= alu_res[AW-1:0];
          free_r <= rdata[TW-1];
          if (mode_r == MODE_FREE) begin
            if (tp_r == hm1_r) begin
              if (!rdata[TW-1] && (rdata != '0)) begin
                state_r <= S_M0;
              end else begin
                res_r.status <= ST_BADFREE;
                state_r <= S_DONE;
              end
            end else if (tp_r > hm1_r) begin
              res_r.status <= ST_BADFREE;
              state_r <= S_DONE;
            end else begin
              state_r <= S_ADV;
            end
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (free_r && !alu_res[TW-1]) begin
            // remainder of two units or less is absorbed
            g_r <= ($unsigned(alu_res) <= TW'(TAG_UNITS)) ? a_r : req_r;
            state_r <= S_G0;
          end else begin
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          if ($unsigned(alu_res) >= $unsigned(ext_idx(last_r))) begin
            res_r.status <= (mode_r == MODE_FREE) ? ST_BADFREE : ST_NOFIT;
            state_r <= S_DONE;
          end else begin
            tp_r <= alu_res[AW-1:0];
            state_r <= S_RD;
          end
        end
        S_G0: begin
          nfs_r <= alu_res;
          state_r <= (g_r == a_r) ? S_G3 : S_G1;
        end
        S_G1: begin
          state_r <= S_G2;
        end
        S_G2: begin
          state_r <= S_G3;
        end
        S_G3: begin
          res_r.address <= alu_res[AW-1:0];
          state_r <= S_G4;
        end
        S_G4: begin
          res_r.granted <= g_r;
          state_r <= S_DONE;
        end
        S_M0: begin
          r0_r <= alu_res[AW-1:0];
          rtag_r <= alu_res[AW-1:0];
          ltag_r <= tp_r;
          state_r <= (tp_r != '0) ? S_M1 : S_M3;
        end
        S_M1: begin
          state_r <= S_M2;
        end
        S_M2: begin
          if (rdata[TW-1]) begin
            ltag_r <= alu_res[AW-1:0];
          end
          state_r <= S_M3;
        end
        S_M3: begin
          state_r <= (r0_r < last_r) ? S_M4 : S_M5;
        end
        S_M4: begin
          if (rdata[TW-1]) begin
            rtag_r <= alu_res[AW-1:0];
          end
          state_r <= S_M5;
        end
        S_M5: begin
          nfs_r <= alu_res;
          state_r <= S_M6;
        end
        S_M6: begin
          state_r <= S_M7;
        end
        S_M7: begin
          state_r <= S_M8;
        end
        S_M8: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (ctl_in.res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/boundary_tag_first_fit_allocator.sv -----
// Boundary-tag first-fit allocator. The arena (arena_units entries, 8..1024,
// clamped on write) is tiled by blocks, each framed by a start and an end tag
// holding the signed payload size (negative = free). An allocate transaction
// walks the blocks from the start of the arena and takes the first free block that fits,
// splitting it unless the leftover is two units or less; a free transaction
// walks to the handle, marks the block free and merges it with free
// neighbors. All tag arithmetic runs through one shared 12-bit adder under
// a sequencer, and the tags sit in a single-port-write, registered-read RAM.
// An allocate reads, sizes and checks each block it visits, then writes the
// chosen block's tags, splitting it where the leftover allows; a free passes
// each block before the handle, then checks and merges the handle's block;
// a null free (handle 0) goes straight to the result. The result
// then sits in an output register, so the sequencer is free once the result
// is handed over. After reset and after every arena_units write the block
// writes the initial two tags and accepts no transaction meanwhile.
// One transaction is in flight at a time.
module boundary_tag_first_fit_allocator (
  input logic       clk,
  input logic       rst_n,
  bta_req_if.sink   in_if,
  bta_rsp_if.source out_if,
  bta_cfg_if.sink   cfg_if
);
  import bta_pkg::*;

  units_t   arena_units_r;
  units_t   cfg_clamped;
  logic     cfg_fire;
  logic     out_valid_r;
  res_t     out_res_r;
  ctl_in_t  ctl_in;
  ctl_out_t ctl_out;
  req_t     req;
  alu_op_t  alu_op;
  tag_t     alu_res;
  ram_req_t ram_req;
  tag_t     rdata;

  // Config is taken only while the sequencer is idle; it has priority
  // over a transaction offered in the same cycle.
  assign cfg_if.ready = ctl_out.idle;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;
  assign in_if.ready  = ctl_out.idle && !cfg_if.valid;

  always_comb begin
    if (cfg_if.arena_units < NW'(UNITS_MIN)) begin
      cfg_clamped = NW'(UNITS_MIN);
    end else if (cfg_if.arena_units > NW'(ARENA_UNITS)) begin
      cfg_clamped = NW'(ARENA_UNITS);
    end else begin
      cfg_clamped = cfg_if.arena_units;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_units_r <= NW'(ARENA_UNITS);
    end else if (cfg_fire) begin
      arena_units_r <= cfg_clamped;
    end
  end

  assign req = '{mode: in_if.mode, req: in_if.request_units, handle: in_if.handle};

  assign ctl_in.start     = in_if.valid && in_if.ready;
  assign ctl_in.init      = cfg_fire;
  // Sequencer may hand over a result when the output slot is empty or
  // being emptied this cycle.
  assign ctl_in.res_ready = !out_valid_r || out_if.ready;

  bta_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_in      (ctl_in),
    .req         (req),
    .arena_units (arena_units_r),
    .alu_res     (alu_res),
    .rdata       (rdata),
    .alu_op      (alu_op),
    .ram_req     (ram_req),
    .ctl_out     (ctl_out)
  );

  bta_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  bta_tag_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl_out.done) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_out.done) begin
      out_res_r <= ctl_out.res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_res_r.status;
  assign out_if.address       = out_res_r.address;
  assign out_if.granted_units = out_res_r.granted;

endmodule

// ----- rtl/bta_chk.sv -----
module bta_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input bta_pkg::status_t status,
  input bta_pkg::idx_t    address,
  input bta_pkg::idx_t    granted,
  input logic             cfg_valid,
  input logic             cfg_ready
);
  import bta_pkg::*;

  // busy after taking a transaction
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a transaction");

  // arena re-init after a config write
  a_init_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("transaction accepted during arena init");

  // failed results carry no grant
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (address == '0) && (granted == '0))
    else $error("non-ok result with address or grant");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(address)
      && $stable(granted))
    else $error("stalled result changed");

endmodule

bind boundary_tag_first_fit_allocator bta_chk u_bta_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .status    (out_if.status),
  .address   (out_if.address),
  .granted   (out_if.granted_units),
  .cfg_valid (cfg_if.valid),
  .cfg_ready (cfg_if.ready)
);
